// ===== rtl/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types and codes for the per-source connection limiter.
// ----------------------------------------------------------------------------
package pcl_pkg;

    localparam int CNT_W = 9;
    localparam int KEY_W = 32;
    localparam int SID_W = 8;
    localparam int ST_W  = 3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_ACCEPTED     = 3'd0;
    localparam logic [ST_W-1:0] ST_STOPPED      = 3'd1;
    localparam logic [ST_W-1:0] ST_TOTAL_LIMIT  = 3'd2;
    localparam logic [ST_W-1:0] ST_SOURCE_LIMIT = 3'd3;
    localparam logic [ST_W-1:0] ST_TABLE_FULL   = 3'd4;
    localparam logic [ST_W-1:0] ST_UNKNOWN      = 3'd5;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STOP  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [SID_W-1:0] session_id;
        logic [KEY_W-1:0] source_ip;
    } t_in_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] active_total;
        logic [CNT_W-1:0] source_count;
    } t_out_req;

    // One source table word; a zero count marks a free entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } t_src_entry;

    // Outcome of one table scan
    typedef struct packed {
        logic             hit;
        logic             free;
        logic [CNT_W-1:0] cnt;
    } t_scan_res;

endpackage

// ===== rtl/pcl_src_mem.sv =====
// ----------------------------------------------------------------------------
// pcl_src_mem
// Source table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcl_src_mem
    import pcl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_src_entry    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_src_entry    o_rdata
);

    t_src_entry r_mem [DEPTH];
    t_src_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcl_match_unit.sv =====
// ----------------------------------------------------------------------------
// pcl_match_unit
// Key comparator stepped over the table once per request: records the
// entry holding the key and the lowest free entry.
// ----------------------------------------------------------------------------
module pcl_match_unit
    import pcl_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_rd_vld,
    input  logic [AW-1:0]    i_rd_idx,
    input  t_src_entry       i_rd_data,
    input  logic [KEY_W-1:0] i_key,
    output t_scan_res        o_res,
    output logic [AW-1:0]    o_hit_idx,
    output logic [AW-1:0]    o_free_idx
);

    logic             r_hit;
    logic             r_free;
    logic [CNT_W-1:0] r_hit_cnt;
    logic [AW-1:0]    r_hit_idx;
    logic [AW-1:0]    r_free_idx;
    logic             used;
    logic             is_hit;
    logic             take_free;

    assign used      = (i_rd_data.cnt != '0);
    assign is_hit    = i_rd_vld && used && (i_rd_data.key == i_key);
    assign take_free = i_rd_vld && !used && !r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (is_hit) begin
                r_hit <= 1'b1;
            end
            if (take_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_hit) begin
            r_hit_idx <= i_rd_idx;
            r_hit_cnt <= i_rd_data.cnt;
        end
        if (take_free) begin
            r_free_idx <= i_rd_idx;
        end
    end

    assign o_res.hit  = r_hit;
    assign o_res.free = r_free;
    assign o_res.cnt  = r_hit_cnt;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

// ===== rtl/per_source_connection_limiter.sv =====
// ----------------------------------------------------------------------------
// per_source_connection_limiter
// Once a request is accepted, the source table is scanned linearly through
// one comparator (one entry per cycle), then S_WAIT and S_DECIDE follow and
// o_out_valid rises; S_DECIDE holds while the previous result is held by
// i_out_stall. The input stalls until then, so one request is handled at a
// time. Reset: synchronous; afterwards a clearing pass zeroes the source
// table counts, with the input stalled (configuration still taken).
// ----------------------------------------------------------------------------
module per_source_connection_limiter
    import pcl_pkg::*;
#(
    parameter int SESSIONS = 256,
    parameter int SOURCES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    // request out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_req,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Session ids are 8 bits wide, so never more than 256 flags are needed
    localparam int SESS_DEPTH = (SESSIONS < 256) ? SESSIONS : 256;
    localparam int SID_AW     = $clog2(SESS_DEPTH);
    localparam int SRC_AW     = $clog2(SOURCES);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    localparam logic [SRC_AW-1:0] LAST_SRC = SRC_AW'(SOURCES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_max_total;
    logic [CNT_W-1:0] r_max_src;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_total <= CNT_W'(256);
            r_max_src   <= CNT_W'(16);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_max_src <= pwdata[CNT_W-1:0];
            end else begin
                r_max_total <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? {{(32-CNT_W){1'b0}}, r_max_src}
                             : {{(32-CNT_W){1'b0}}, r_max_total};

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [2:0]        r_state;
    logic [SRC_AW-1:0] r_ptr;
    t_in_req           r_req;
    logic              r_rd_vld;
    logic [SRC_AW-1:0] r_rd_idx;
    logic [CNT_W-1:0]  r_total;
    logic [SESS_DEPTH-1:0] r_sess_act;
    logic              r_out_valid;
    t_out_req          r_out_req;

    logic              in_acc;
    logic              out_free;
    logic              commit;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    // Output slot can take a new result this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == S_DECIDE) && out_free;

    // ------------------------------------------------------------------
    // Source table and scan comparator
    // ------------------------------------------------------------------
    t_src_entry        rd_data;
    t_scan_res         scan;
    logic [SRC_AW-1:0] hit_idx;
    logic [SRC_AW-1:0] free_idx;

    logic              mem_we;
    logic [SRC_AW-1:0] mem_waddr;
    t_src_entry        mem_wdata;
    logic              mem_re;

    logic              dec_we;
    logic [SRC_AW-1:0] dec_waddr;
    t_src_entry        dec_wdata;

    assign mem_re = (r_state == S_SCAN);

    // Clearing pass owns the write port until the table is zeroed
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_ptr;
            mem_wdata = '0;
        end else begin
            mem_we    = commit && dec_we;
            mem_waddr = dec_waddr;
            mem_wdata = dec_wdata;
        end
    end

    pcl_src_mem #(
        .DEPTH (SOURCES),
        .AW    (SRC_AW)
    ) u_src_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    pcl_match_unit #(
        .AW (SRC_AW)
    ) u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_rd_vld   (r_rd_vld),
        .i_rd_idx   (r_rd_idx),
        .i_rd_data  (rd_data),
        .i_key      (r_req.source_ip),
        .o_res      (scan),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    // ------------------------------------------------------------------
    // Decision, taken once the scan result has settled
    // ------------------------------------------------------------------
    logic              sid_ok;
    logic [SID_AW-1:0] sid_idx;
    logic              r_act;
    logic              act;
    logic [CNT_W-1:0]  cnt;
    logic [ST_W-1:0]   n_status;
    logic [CNT_W-1:0]  n_total;
    logic [CNT_W-1:0]  n_cnt;
    logic              sess_set;
    logic              sess_clr;

    assign sid_ok  = (13'(r_req.session_id) < 13'(SESSIONS));
    assign sid_idx = r_req.session_id[SID_AW-1:0];

    // Session flag of the held request, registered; settled long
    // before the decision as the flags only change on commit
    always_ff @(posedge i_clk) begin
        r_act <= r_sess_act[sid_idx];
    end

    assign act     = sid_ok && r_act;
    // A source without an entry counts as zero
    assign cnt     = scan.hit ? scan.cnt : '0;

    always_comb begin
        n_status  = ST_UNKNOWN;
        n_total   = r_total;
        n_cnt     = cnt;
        sess_set  = 1'b0;
        sess_clr  = 1'b0;
        dec_we    = 1'b0;
        dec_waddr = hit_idx;
        dec_wdata = '{key: r_req.source_ip, cnt: cnt};
        if (r_req.command == CMD_START) begin
            // order: duplicate, total limit, source limit, table full
            priority if (!sid_ok || act) begin
                n_status = ST_UNKNOWN;
            end else if (r_total >= r_max_total) begin
                n_status = ST_TOTAL_LIMIT;
            end else if (cnt >= r_max_src) begin
                n_status = ST_SOURCE_LIMIT;
            end else if (!scan.hit && !scan.free) begin
                n_status = ST_TABLE_FULL;
            end else begin
                n_status      = ST_ACCEPTED;
                n_total       = r_total + 1'b1;
                n_cnt         = cnt + 1'b1;
                sess_set      = 1'b1;
                dec_we        = 1'b1;
                dec_waddr     = scan.hit ? hit_idx : free_idx;
                dec_wdata.cnt = cnt + 1'b1;
            end
        end else begin
            if (!sid_ok || !act) begin
                n_status = ST_UNKNOWN;
            end else begin
                n_status = ST_STOPPED;
                sess_clr = 1'b1;
                if (r_total != '0) begin
                    n_total = r_total - 1'b1;
                end
                // stop of a source with no entry leaves the table alone
                if (scan.hit) begin
                    if (cnt != '0) begin
                        n_cnt = cnt - 1'b1;
                    end
                    dec_we        = 1'b1;
                    dec_wdata.cnt = n_cnt;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= mem_re;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_ptr == LAST_SRC) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_ptr   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_ptr == LAST_SRC) begin
                        r_ptr   <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_WAIT: begin
                    // last table word is compared in this cycle
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr;
        if (in_acc) begin
            r_req <= i_in_req;
        end
    end

    // Session flags and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess_act <= '0;
            r_total    <= '0;
        end else if (commit) begin
            r_total <= n_total;
            if (sess_set) begin
                r_sess_act[sid_idx] <= 1'b1;
            end else if (sess_clr) begin
                r_sess_act[sid_idx] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_req.status       <= n_status;
            r_out_req.active_total <= n_total;
            r_out_req.source_count <= n_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(SESS_DEPTH))
        else $error("active total beyond session count");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN) && (r_ptr == '0))
        else $error("accepted request did not start a scan");

    a_out_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DECIDE)
        else $error("result raised outside decision");

    a_write_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && dec_we) |-> (scan.hit || scan.free))
        else $error("table write without a found entry");
`endif

endmodule

// ===== bench/per_source_connection_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// per_source_connection_limiter_tb
// Self-checking bench for the per-source connection limiter. Start and stop
// requests go in over the valid/stall channel and the limits are written over
// the APB-style port. A predictor in the bench keeps its own session, source
// table and total state, works out the verdict of each accepted request, and
// the verdicts that come out are checked in order, field by field.
// ----------------------------------------------------------------------------
module per_source_connection_limiter_tb;
    import pcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SESSION_IDS = 256;
    localparam int SRC_SLOTS   = 64;
    // accept to result
    localparam int SCAN_CYCLES = SRC_SLOTS + 2;

    // register byte addresses
    localparam logic [2:0] REG_MAX_TOTAL      = 3'd0;
    localparam logic [2:0] REG_MAX_PER_SOURCE = 3'd4;

    // spreads generated addresses apart; odd, so 64 steps never repeat
    localparam logic [31:0] ADDR_STRIDE = 32'h9E37_79B1;

    // ------------------------------------------------------------------------
    // DUT signals; the inputs are known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_req     i_in_req   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_req    o_out_req;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    per_source_connection_limiter #(
        .SESSIONS (SESSION_IDS),
        .SOURCES  (SRC_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 8 ns clock
    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: mirrors the admission tables inside the block
    // ------------------------------------------------------------------------
    bit          live_session [SESSION_IDS];
    logic [31:0] src_addr     [SRC_SLOTS];   // only read where src_busy is set
    bit          src_busy     [SRC_SLOTS];
    logic [8:0]  src_cnt      [SRC_SLOTS];
    logic [8:0]  live_total   = '0;
    logic [8:0]  cap_total    = 9'd256;      // reset values of the limits
    logic [8:0]  cap_source   = 9'd16;

    t_out_req    pending_verdicts [$];
    t_out_req    want_verdict;

    // stimulus bookkeeping
    bit   [31:0] sess_from [SESSION_IDS];    // address a live session started with
    logic [31:0] ip_pool   [96];
    int          pool_size      = 1;
    bit          idle_on        = 1'b1;
    int          stall_left     = 0;
    int          mismatches     = 0;
    int          requests_sent  = 0;
    int          settings_used  = 0;
    int          status_seen [6];

    // Verdict for one request, updating the mirrored state as the block would.
    // Check order on a start: duplicate, total limit, source limit, table full.
    function automatic t_out_req admit_request(input t_in_req req);
        t_out_req   verdict;
        int         slot;
        int         i;
        logic [8:0] cnt;
        slot = -1;
        cnt  = '0;
        for (i = 0; i < SRC_SLOTS; i++) begin
            if (slot < 0 && src_busy[i] && src_addr[i] == req.source_ip)
                slot = i;
        end
        if (slot >= 0)
            cnt = src_cnt[slot];

        if (req.command == CMD_START) begin
            if (live_session[req.session_id]) begin
                verdict.status = ST_UNKNOWN;
            end else if (live_total >= cap_total) begin
                verdict.status = ST_TOTAL_LIMIT;
            end else if (cnt >= cap_source) begin
                verdict.status = ST_SOURCE_LIMIT;
            end else begin
                // new source takes the lowest free slot
                if (slot < 0) begin
                    for (i = 0; i < SRC_SLOTS; i++) begin
                        if (slot < 0 && !src_busy[i])
                            slot = i;
                    end
                    if (slot >= 0) begin
                        src_busy[slot] = 1'b1;
                        src_addr[slot] = req.source_ip;
                        src_cnt[slot]  = '0;
                    end
                end
                if (slot < 0) begin
                    verdict.status = ST_TABLE_FULL;
                end else begin
                    live_session[req.session_id] = 1'b1;
                    live_total     = live_total + 9'd1;
                    src_cnt[slot]  = src_cnt[slot] + 9'd1;
                    cnt            = src_cnt[slot];
                    verdict.status = ST_ACCEPTED;
                end
            end
        end else begin
            if (!live_session[req.session_id]) begin
                verdict.status = ST_UNKNOWN;
            end else begin
                // the stop's own address decides which count drops
                live_session[req.session_id] = 1'b0;
                if (live_total != 0)
                    live_total = live_total - 9'd1;
                if (slot >= 0) begin
                    if (src_cnt[slot] != 0)
                        src_cnt[slot] = src_cnt[slot] - 9'd1;
                    cnt = src_cnt[slot];
                    if (cnt == 0)
                        src_busy[slot] = 1'b0;
                end
                verdict.status = ST_STOPPED;
            end
        end
        verdict.active_total = live_total;
        verdict.source_count = cnt;
        return verdict;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, none when idle_on drops
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!idle_on) begin
            stall_left  = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 8) begin
            stall_left  = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Every result taken is checked against the oldest outstanding verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with nothing outstanding: status %0d total %0d count %0d",
                       o_out_req.status, o_out_req.active_total, o_out_req.source_count);
                mismatches++;
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (o_out_req.status !== want_verdict.status) begin
                    $error("status: expected %0d, actual %0d",
                           want_verdict.status, o_out_req.status);
                    mismatches++;
                end
                if (o_out_req.active_total !== want_verdict.active_total) begin
                    $error("active_total: expected %0d, actual %0d",
                           want_verdict.active_total, o_out_req.active_total);
                    mismatches++;
                end
                if (o_out_req.source_count !== want_verdict.source_count) begin
                    $error("source_count: expected %0d, actual %0d",
                           want_verdict.source_count, o_out_req.source_count);
                    mismatches++;
                end
            end
            if (o_out_req.status <= ST_UNKNOWN)
                status_seen[o_out_req.status]++;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers. All of them start and end on a falling edge.
    // ------------------------------------------------------------------------

    // One request. Valid is left high on return so back-to-back requests drop
    // it only for a random idle gap; anything else that follows lowers it first.
    task automatic send_request(input t_in_req req);
        t_out_req verdict;
        int       gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        verdict = admit_request(req);
        pending_verdicts.push_back(verdict);
        if (verdict.status == ST_ACCEPTED)
            sess_from[req.session_id] = req.source_ip;
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic cmd, input logic [7:0] sid,
                               input logic [31:0] addr);
        t_in_req req;
        req.command    = cmd;
        req.session_id = sid;
        req.source_ip  = addr;
        send_request(req);
    endtask

    // Sender holds off until every outstanding verdict has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
    endtask

    // APB write: setup phase, then access until pready, then an idle phase
    task automatic write_register(input logic [2:0] addr, input logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {23'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (addr)
            REG_MAX_TOTAL:      cap_total  = value;
            REG_MAX_PER_SOURCE: cap_source = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Only ever called with nothing outstanding
    task automatic set_limits(input logic [8:0] total_lim, input logic [8:0] source_lim);
        write_register(REG_MAX_TOTAL, total_lim);
        write_register(REG_MAX_PER_SOURCE, source_lim);
        settings_used++;
    endtask

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    task automatic fill_pool(input int n);
        int i;
        pool_size = n;
        for (i = 0; i < n; i++)
            ip_pool[i] = $urandom();
    endtask

    // Stop every live session from the address it started with
    task automatic stop_all_live();
        int s;
        for (s = 0; s < SESSION_IDS; s++) begin
            if (live_session[s])
                send_fields(CMD_STOP, 8'(s), sess_from[s]);
        end
    endtask

    // Mostly well-formed traffic: starts of idle sessions from the pool and
    // stops of live ones from their own address. About one request in seven
    // is noise: random command, id and address, so duplicates, unknown stops
    // and stops from the wrong source turn up as well.
    task automatic send_mixed(input int count, input int start_pct);
        t_in_req req;
        int      k;
        int      tries;
        for (k = 0; k < count; k++) begin
            req.session_id = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 15) begin
                req.command   = 1'($urandom_range(0, 1));
                req.source_ip = $urandom_range(0, 1) ? $urandom() : pool_ip();
            end else if ($urandom_range(0, 99) < start_pct) begin
                tries = 0;
                while (live_session[req.session_id] && tries < 32) begin
                    req.session_id = 8'($urandom_range(0, 255));
                    tries++;
                end
                req.command   = CMD_START;
                req.source_ip = pool_ip();
            end else begin
                tries = 0;
                while (!live_session[req.session_id] && tries < 32) begin
                    req.session_id = 8'($urandom_range(0, 255));
                    tries++;
                end
                req.command   = CMD_STOP;
                req.source_ip = sess_from[req.session_id];
            end
            send_request(req);
            // now and then let the pipe empty completely mid-stream
            if (k % 64 == 63 && $urandom_range(0, 1) == 1)
                wait_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Tight limits so the duplicate, total limit and source limit refusals show up within a dozen requests
    task automatic test_directed();
        set_limits(9'd3, 9'd2);
        send_fields(CMD_START, 8'd0,   32'h0000_0000);   // accepted
        send_fields(CMD_START, 8'd0,   32'h0000_0000);   // duplicate
        send_fields(CMD_START, 8'd255, 32'hFFFF_FFFF);   // top id, top address
        send_fields(CMD_START, 8'd1,   32'h0000_0000);   // source at 2
        send_fields(CMD_START, 8'd2,   32'h0000_0001);   // total limit
        send_fields(CMD_STOP,  8'd255, 32'hFFFF_FFFF);   // entry freed
        send_fields(CMD_START, 8'd2,   32'h0000_0000);   // source limit
        send_fields(CMD_START, 8'd2,   32'h8000_0001);   // accepted, total full
        send_fields(CMD_STOP,  8'd7,   32'h0000_0005);   // inactive session
        send_fields(CMD_STOP,  8'd1,   32'h1234_5678);   // source has no entry
        send_fields(CMD_STOP,  8'd0,   32'h0000_0000);   // stopped
        send_fields(CMD_STOP,  8'd0,   32'h0000_0000);   // already stopped
        send_fields(CMD_STOP,  8'd2,   32'h0000_0000);   // wrong source, frees it
    endtask

    // Zero limits refuse every start; limits past 256 never bite
    task automatic test_zero_and_wide_limits();
        wait_drain();
        set_limits(9'd256, 9'd16);
        send_fields(CMD_START, 8'd9,  32'hA5A5_A5A5);
        wait_drain();
        set_limits(9'd0, 9'd16);
        send_fields(CMD_START, 8'd9,  32'hA5A5_A5A5);    // duplicate wins over total
        send_fields(CMD_START, 8'd10, 32'h5A5A_5A5A);    // total limit
        send_fields(CMD_STOP,  8'd9,  32'hA5A5_A5A5);    // stops still go through
        wait_drain();
        set_limits(9'd256, 9'd0);
        send_fields(CMD_START, 8'd11, 32'h0F0F_0F0F);    // source limit at zero
        wait_drain();
        set_limits(9'd511, 9'd511);
        send_fields(CMD_START, 8'd11, 32'h0F0F_0F0F);
        send_fields(CMD_STOP,  8'd11, 32'h0F0F_0F0F);
    endtask

    // Fill the source table, overflow it, then free a slot and reuse it
    task automatic test_table_full();
        logic [31:0] base;
        int          j;
        stop_all_live();
        wait_drain();
        set_limits(9'd256, 9'd256);
        base = $urandom();
        for (j = 0; j < 68; j++)
            send_fields(CMD_START, 8'(j), base + 32'(j) * ADDR_STRIDE);
        send_fields(CMD_START, 8'd100, base + 32'd5 * ADDR_STRIDE);
        send_fields(CMD_STOP,  8'd3,   base + 32'd3 * ADDR_STRIDE);
        send_fields(CMD_START, 8'd64,  base + 32'd64 * ADDR_STRIDE);
        stop_all_live();
    endtask

    // Phases of mixed traffic, each under its own limits
    task automatic test_random_traffic();
        int         ph;
        int         n;
        int         pct;
        logic [8:0] lim_t;
        logic [8:0] lim_s;
        for (ph = 0; ph < 8; ph++) begin
            n   = 180;
            pct = 60;
            case (ph)
                0: begin lim_t = 9'd256; lim_s = 9'd16;  fill_pool(10); end
                1: begin lim_t = 9'd8;   lim_s = 9'd3;   fill_pool(6);  pct = 55; end
                2: begin lim_t = 9'd0;   lim_s = 9'd16;  fill_pool(8);  n = 60; end
                3: begin lim_t = 9'd300; lim_s = 9'd511; fill_pool(90); n = 200; pct = 75; end
                4: begin lim_t = 9'd256; lim_s = 9'd1;   fill_pool(40); end
                5: begin lim_t = 9'd1;   lim_s = 9'd1;   fill_pool(4);  n = 100; end
                6: begin lim_t = 9'd256; lim_s = 9'd256; fill_pool(3);  n = 200; end
                default: begin
                    lim_t = 9'($urandom_range(1, 256));
                    lim_s = 9'($urandom_range(1, 32));
                    fill_pool($urandom_range(4, 80));
                    n     = 200;
                    pct   = 55;
                end
            endcase
            // every third phase runs without any idling
            idle_on = (ph % 3 != 2);
            wait_drain();
            set_limits(lim_t, lim_s);
            send_mixed(n, pct);
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_unthrottled_tail();
        idle_on = 1'b0;
        wait_drain();
        set_limits(9'($urandom_range(16, 256)), 9'($urandom_range(2, 16)));
        fill_pool(16);
        send_mixed(150, 55);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass after reset shows up as input stall, nothing more

        test_directed();
        test_zero_and_wide_limits();
        test_table_full();
        test_random_traffic();
        test_unthrottled_tail();

        wait_drain();
        repeat (SCAN_CYCLES + 16) @(negedge i_clk);

        $display("%0d requests under %0d limit settings; verdicts seen: %0d accepted,",
                 requests_sent, settings_used, status_seen[ST_ACCEPTED]);
        $display("%0d stopped, %0d total limit, %0d source limit, %0d table full, %0d unknown",
                 status_seen[ST_STOPPED], status_seen[ST_TOTAL_LIMIT],
                 status_seen[ST_SOURCE_LIMIT], status_seen[ST_TABLE_FULL],
                 status_seen[ST_UNKNOWN]);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("per_source_connection_limiter regression: pass");
        end else begin
            $display("per_source_connection_limiter regression: fail");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run (~2 ms)
    initial begin
        #20_000_000;
        $display("per_source_connection_limiter regression: fail");
        $finish;
    end

endmodule
